@@ sv/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// shared types and constants for the keyframe track sampler
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int TIME_BITS_DEF = 24;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [2:0] ST_SAMPLED = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADIDX  = 3'd3;
    localparam logic [2:0] ST_UPDATED = 3'd4;

    localparam logic CFG_EASING = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRAP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BRK_RD0,
        S_BRK_RD1,
        S_BRK_RD2,
        S_BRK_RD3,
        S_DIV,
        S_EASE_PREP,
        S_EASE_MUL,
        S_INTERP,
        S_INTERP2,
        S_SCALE,
        S_SCALE2,
        S_INS_RD,
        S_INS_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } state_t;

    // result request held in the output register
    typedef struct packed {
        logic [31:0] sample_value;
        logic [2:0]  status;
        logic [5:0]  first_key_index;
        logic [6:0]  key_total;
    } result_t;

endpackage

@@ sv/kts_ram.sv @@
// ----------------------------------------------------------------------------
// kts_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module kts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/kts_div.sv @@
// ----------------------------------------------------------------------------
// kts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kts_div #(
    parameter int NBITS = 40,
    parameter int DBITS = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NBITS-1:0] num,
    input  logic [DBITS-1:0] den,
    output logic             done,
    output logic [NBITS-1:0] quot
);

    localparam int CW = $clog2(NBITS + 1);

    logic [NBITS-1:0] q_reg, q_next;
    logic [DBITS:0]   r_reg, r_next;
    logic [DBITS-1:0] d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DBITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DBITS-1:0], q_reg[NBITS-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NBITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NBITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NBITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = q_next;

endmodule

@@ sv/keyframe_track_sampler_top.sv @@
// ----------------------------------------------------------------------------
// keyframe_track_sampler_top
// time-sorted keyframe table with eased, weighted sampling
// ----------------------------------------------------------------------------
// Keys live in two single-port RAMs (times and values), one entry per key,
// with the count in a register. One request is processed at a time. A sample
// wraps the time (iterative subtraction), binary searches the times (a read
// and a compare state per probe, log2(MAX_KEYS)+1 probes), reads the two
// bracketing keys (states S_BRK_RD0 to S_BRK_RD3), runs a restoring divider
// for the fraction (TIME_BITS+16 quotient bits), raises it to the easing
// power (one registered multiply per cycle, power up to five), then
// interpolates and scales (S_INTERP, S_INTERP2, S_SCALE, S_SCALE2). An insert
// scans for its slot (a read and a compare per key) and then shifts the tail
// up (a read and a write per moved key); a remove shifts the tail down the
// same way. The result waits in an output register; a new request is taken
// once that register is free. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
module keyframe_track_sampler_top #(
    parameter int TIME_BITS = kts_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [TIME_BITS-1:0] time_pos,
    input  logic signed [31:0]   key_value,
    input  logic [5:0]           key_index,
    input  logic signed [15:0]   blend_weight,
    input  logic signed [15:0]   blend_scale,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   sample_value,
    output logic [2:0]           status,
    output logic [5:0]           first_key_index,
    output logic [6:0]           key_total,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    import kts_pkg::*;

    // table size is tied to the index and count field widths
    localparam int MAX_KEYS = MAX_KEYS_DEF;
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int TB = TIME_BITS;
    localparam int NB = TB + 16;

    state_t state_reg, state_next;

    // configuration
    logic [3:0]  ease_reg;
    logic [TB-1:0] len_reg;

    // request holding
    logic [1:0]  act_reg, act_next;
    logic [TB-1:0] t_reg, t_next;
    logic signed [31:0] kv_reg;
    logic signed [15:0] w_reg, s_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] j_reg, j_next;

    // bracket
    logic [TB-1:0] t1_reg, t1_next;
    logic [TB:0]   t2_reg, t2_next;
    logic signed [31:0] v1_reg, v1_next, v2_reg, v2_next;
    logic [AW-1:0] i_reg, i_next;

    // arithmetic
    logic [16:0] f_reg, f_next;
    logic [17:0] x_reg, x_next;
    logic [17:0] p_reg, p_next;
    logic [2:0]  n_reg, n_next;
    logic [1:0]  kind_reg, kind_next;
    logic [16:0] e_reg, e_next;
    logic signed [50:0] m_reg, m_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] ws_reg, ws_next;
    logic signed [63:0] prod_reg, prod_next;

    // easing power and curve kind decoded from the mode
    logic [2:0]  ease_n;
    logic [1:0]  ease_kind;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [TB-1:0] ram_wt, ram_rt;
    logic [31:0]   ram_wv, ram_rv;

    // divider
    logic          div_start, div_done;
    logic [NB-1:0] div_num, div_q;
    logic [TB:0]   div_den;

    result_t res_reg, res_next;
    logic    ov_reg, ov_next;

    logic in_acc, out_acc;
    logic [35:0] pm;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ov_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign cfg_ready = 1'b1;

    kts_ram #(.WIDTH(TB), .DEPTH(MAX_KEYS)) u_times (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wt), .rdata(ram_rt)
    );
    kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_values (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wv), .rdata(ram_rv)
    );
    kts_div #(.NBITS(NB), .DBITS(TB + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    // kind: 0 in, 1 out, 2 in-out; power 2..5 in groups of three modes
    always_comb
    begin
        case (ease_reg)
            4'd1, 4'd4, 4'd7, 4'd10: ease_kind = 2'd0;
            4'd2, 4'd5, 4'd8, 4'd11: ease_kind = 2'd1;
            default:                 ease_kind = 2'd2;
        endcase
        case (ease_reg)
            4'd1, 4'd2, 4'd3: ease_n = 3'd2;
            4'd4, 4'd5, 4'd6: ease_n = 3'd3;
            4'd7, 4'd8, 4'd9: ease_n = 3'd4;
            default:          ease_n = 3'd5;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        t_next      = t_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        j_next      = j_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        i_next      = i_reg;
        f_next      = f_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        kind_next   = kind_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        val_next    = val_reg;
        ws_next     = ws_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        ram_we      = 1'b0;
        ram_addr    = '0;
        ram_wt      = t_reg;
        ram_wv      = kv_reg;
        div_start   = 1'b0;
        div_num     = {(t_reg - t1_reg), 16'd0};
        div_den     = t2_reg - {1'b0, t1_reg};
        pm          = p_reg * x_reg;

        if (out_acc)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    act_next = action;
                    t_next   = time_pos;
                    res_next = '{sample_value: '0, status: ST_NONE,
                                 first_key_index: '0, key_total: 7'(cnt_reg)};
                    case (action)
                        ACT_SAMPLE:
                        begin
                            if (cnt_reg != '0 && blend_weight != '0 && blend_scale != '0)
                            begin
                                state_next = S_WRAP;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (cnt_reg >= CW'(MAX_KEYS))
                            begin
                                res_next.status = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if ({1'b0, key_index} >= 7'(cnt_reg))
                            begin
                                res_next.status = ST_BADIDX;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                j_next     = CW'(key_index);
                                state_next = S_SHIFT_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // t = (t-1) % len + 1 by repeated subtraction
            S_WRAP:
            begin
                if (len_reg != '0 && t_reg > len_reg)
                begin
                    t_next = t_reg - len_reg;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                    state_next = S_SRCH_RD;
                end
            end

            S_SRCH_RD:
            begin
                ram_addr = AW'((lo_reg + hi_reg) >> 1);
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_BRK_RD0;
                end
            end

            S_SRCH_CMP:
            begin
                if (ram_rt < t_reg)
                begin
                    lo_next = ((lo_reg + hi_reg) >> 1) + 1'b1;
                end
                else
                begin
                    hi_next = (lo_reg + hi_reg) >> 1;
                end
                state_next = S_SRCH_RD;
            end

            // read key at lo (or key 0 on wrap)
            S_BRK_RD0:
            begin
                if (lo_reg >= cnt_reg)
                begin
                    ram_addr = '0;
                end
                else
                begin
                    ram_addr = AW'(lo_reg);
                end
                state_next = S_BRK_RD1;
            end

            S_BRK_RD1:
            begin
                v2_next = ram_rv;
                if (lo_reg >= cnt_reg)
                begin
                    t2_next = {1'b0, len_reg} + {1'b0, ram_rt};
                    i_next  = AW'(cnt_reg - 1'b1);
                end
                else
                begin
                    t2_next = {1'b0, ram_rt};
                    if (lo_reg != '0 && t_reg < ram_rt)
                    begin
                        i_next = AW'(lo_reg - 1'b1);
                    end
                    else
                    begin
                        i_next = AW'(lo_reg);
                    end
                end
                state_next = S_BRK_RD2;
            end

            S_BRK_RD2:
            begin
                ram_addr   = i_reg;
                state_next = S_BRK_RD3;
            end

            S_BRK_RD3:
            begin
                t1_next = ram_rt;
                v1_next = ram_rv;
                f_next  = '0;
                if (t2_reg > {1'b0, ram_rt} && t_reg > ram_rt)
                begin
                    div_start  = 1'b1;
                    div_num    = {(t_reg - ram_rt), 16'd0};
                    div_den    = t2_reg - {1'b0, ram_rt};
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_EASE_PREP;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_q > NB'(17'h10000))
                    begin
                        f_next = 17'h10000;
                    end
                    else
                    begin
                        f_next = div_q[16:0];
                    end
                    state_next = S_EASE_PREP;
                end
            end

            // pick base and power for the easing curve, or pass the fraction through when easing is off
            S_EASE_PREP:
            begin
                if (ease_reg < 4'd1 || ease_reg > 4'd12)
                begin
                    e_next     = f_reg;
                    state_next = S_INTERP;
                end
                else
                begin
                    n_next    = ease_n;
                    kind_next = ease_kind;
                    case (ease_kind)
                        2'd0:    x_next = {1'b0, f_reg};
                        2'd1:    x_next = {1'b0, 17'h10000 - f_reg};
                        default:
                        begin
                            if (f_reg < 17'h08000)
                                x_next = {f_reg, 1'b0};
                            else
                                x_next = {17'h10000 - f_reg, 1'b0};
                        end
                    endcase
                    p_next     = x_next;
                    state_next = S_EASE_MUL;
                end
            end

            S_EASE_MUL:
            begin
                if (n_reg > 3'd1)
                begin
                    p_next = 18'(pm >> 16);
                    n_next = n_reg - 1'b1;
                end
                else
                begin
                    case (kind_reg)
                        2'd0: e_next = p_reg[16:0];
                        2'd1: e_next = 17'h10000 - p_reg[16:0];
                        default:
                        begin
                            if (f_reg < 17'h08000)
                                e_next = p_reg[17:1];
                            else
                                e_next = 17'h10000 - p_reg[17:1];
                        end
                    endcase
                    state_next = S_INTERP;
                end
            end

            S_INTERP:
            begin
                m_next     = $signed({1'b0, e_reg}) * ($signed({v2_reg[31], v2_reg})
                             - $signed({v1_reg[31], v1_reg}));
                ws_next    = w_reg * s_reg;
                state_next = S_INTERP2;
            end

            S_INTERP2:
            begin
                val_next   = 32'(v1_reg + 32'(m_reg >>> 16));
                state_next = S_SCALE;
            end

            S_SCALE:
            begin
                prod_next  = val_reg * ws_reg;
                state_next = S_SCALE2;
            end

            S_SCALE2:
            begin
                if ((prod_reg >>> 28) > 64'sd2147483647)
                    res_next.sample_value = 32'h7fffffff;
                else if ((prod_reg >>> 28) < -64'sd2147483648)
                    res_next.sample_value = 32'h80000000;
                else
                    res_next.sample_value = 32'(prod_reg >>> 28);
                res_next.status          = ST_SAMPLED;
                res_next.first_key_index = 6'(i_reg);
                state_next = S_DONE;
            end

            // insert: find first slot with time > t
            S_INS_RD:
            begin
                ram_addr = AW'(lo_reg);
                if (lo_reg < cnt_reg)
                begin
                    state_next = S_INS_CMP;
                end
                else
                begin
                    j_next     = cnt_reg;
                    state_next = S_SHIFT_RD;
                end
            end

            S_INS_CMP:
            begin
                if (ram_rt <= t_reg)
                begin
                    lo_next    = lo_reg + 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    j_next     = cnt_reg;
                    state_next = S_SHIFT_RD;
                end
            end

            // shift one entry: insert moves j-1 -> j, remove moves j+1 -> j
            S_SHIFT_RD:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (j_reg > lo_reg)
                    begin
                        ram_addr   = AW'(j_reg - 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    if (j_reg + 1'b1 < cnt_reg)
                    begin
                        ram_addr   = AW'(j_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                    else
                    begin
                        cnt_next          = cnt_reg - 1'b1;
                        res_next.status   = ST_UPDATED;
                        res_next.key_total = 7'(cnt_reg - 1'b1);
                        state_next = S_DONE;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                ram_we   = 1'b1;
                ram_addr = AW'(j_reg);
                ram_wt   = ram_rt;
                ram_wv   = ram_rv;
                if (act_reg == ACT_INSERT)
                    j_next = j_reg - 1'b1;
                else
                    j_next = j_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end

            S_PUT:
            begin
                ram_we             = 1'b1;
                ram_addr           = AW'(lo_reg);
                cnt_next           = cnt_reg + 1'b1;
                res_next.status    = ST_UPDATED;
                res_next.key_total = 7'(cnt_reg + 1'b1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            ease_reg  <= '0;
            len_reg   <= TB'(65536);
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_EASING: ease_reg <= cfg_data[3:0];
                    CFG_LENGTH: len_reg  <= cfg_data[TB-1:0];
                    default:    ease_reg <= ease_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kv_reg  <= key_value;
            w_reg   <= blend_weight;
            s_reg   <= blend_scale;
        end
        act_reg    <= act_next;
        t_reg      <= t_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        i_reg      <= i_next;
        f_reg      <= f_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        kind_reg   <= kind_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        val_reg    <= val_next;
        ws_reg     <= ws_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
    end

    assign out_valid       = ov_reg;
    assign sample_value    = res_reg.sample_value;
    assign status          = res_reg.status;
    assign first_key_index = res_reg.first_key_index;
    assign key_total       = res_reg.key_total;

    // key count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_KEYS))
        else $error("key count overflow");

    // no new request while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) ov_reg |-> in_stall)
        else $error("request taken with result pending");

    // a non-sample result always reports zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && res_reg.status != ST_SAMPLED) |-> (res_reg.sample_value == '0))
        else $error("value on non-sample result");

endmodule
